// File: rtl/balp_pkg.sv
// Package of shared types and character constants for the byte array literal parser.
package balp_pkg;

    localparam int unsigned CH_W   = 8;
    localparam int unsigned BYTE_W = 8;

    localparam logic [CH_W-1:0] CH_END    = 8'h00;
    localparam logic [CH_W-1:0] CH_ZERO   = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE   = 8'h39;
    localparam logic [CH_W-1:0] CH_UC_A   = 8'h41;
    localparam logic [CH_W-1:0] CH_UC_F   = 8'h46;
    localparam logic [CH_W-1:0] CH_LC_A   = 8'h61;
    localparam logic [CH_W-1:0] CH_LC_F   = 8'h66;
    localparam logic [CH_W-1:0] CH_X      = 8'h78;
    localparam logic [CH_W-1:0] UC_OFFSET = 8'h37;
    localparam logic [CH_W-1:0] LC_OFFSET = 8'h57;

    typedef enum logic [4:0] {
        MODE_IDLE = 5'b00001,
        MODE_ZERO = 5'b00010,
        MODE_DEC  = 5'b00100,
        MODE_HEX1 = 5'b01000,
        MODE_HEX2 = 5'b10000
    } mode_t;

    // One parse step's outcome, handed to the output register.
    typedef struct packed {
        logic              emit;
        logic [BYTE_W-1:0] value;
        logic              at_end;
    } step_res_t;

endpackage

// File: rtl/balp_in_reg.sv
// Input register holding one accepted character item.
module balp_in_reg
    import balp_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [CH_W-1:0] s_tdata,
    input  logic            advance,
    output logic            in_valid,
    output logic [CH_W-1:0] in_ch
);

    logic            valid_reg;
    logic            valid_next;
    logic [CH_W-1:0] ch_reg;

    assign s_tready   = !valid_reg || advance;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !advance);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            ch_reg <= s_tdata;
        end
    end

    assign in_valid = valid_reg;
    assign in_ch    = ch_reg;

endmodule

// File: rtl/balp_step.sv
// Parse state (mode and accumulator) and the per-character update logic.
module balp_step
    import balp_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            advance,
    input  logic [CH_W-1:0] in_ch,
    output step_res_t       res
);

    mode_t             mode_reg;
    mode_t             mode_next;
    logic [BYTE_W-1:0] accum_reg;
    logic [BYTE_W-1:0] accum_next;

    logic              is_dec;
    logic              is_uc;
    logic              is_lc;
    logic              is_hex;
    logic [3:0]        hex_val;
    logic [BYTE_W-1:0] dec_val;
    logic [BYTE_W-1:0] dec_acc;

    assign is_dec  = (in_ch >= CH_ZERO) && (in_ch <= CH_NINE);
    assign is_uc   = (in_ch >= CH_UC_A) && (in_ch <= CH_UC_F);
    assign is_lc   = (in_ch >= CH_LC_A) && (in_ch <= CH_LC_F);
    assign is_hex  = is_dec || is_uc || is_lc;
    assign dec_val = in_ch - CH_ZERO;

    always_comb begin
        logic [CH_W-1:0] diff;
        if (is_uc) begin
            diff = in_ch - UC_OFFSET;
        end else if (is_lc) begin
            diff = in_ch - LC_OFFSET;
        end else begin
            diff = in_ch - CH_ZERO;
        end
        hex_val = diff[3:0];
    end

    // accum * 10 + digit, kept modulo 256
    assign dec_acc = (accum_reg << 3) + (accum_reg << 1) + dec_val;

    always_comb begin
        mode_next  = mode_reg;
        accum_next = accum_reg;
        res.emit   = 1'b0;
        res.value  = accum_reg;
        res.at_end = 1'b0;
        if (in_ch == CH_END) begin
            res.at_end = 1'b1;
            res.emit   = (mode_reg != MODE_IDLE);
            res.value  = (mode_reg == MODE_ZERO) ? '0 : accum_reg;
            mode_next  = MODE_IDLE;
            accum_next = '0;
        end else begin
            case (mode_reg)
                MODE_ZERO: begin
                    if (in_ch == CH_X) begin
                        mode_next = MODE_HEX1;
                    end else if (is_dec) begin
                        accum_next = dec_val;
                        mode_next  = MODE_DEC;
                    end else begin
                        accum_next = '0;
                        res.emit   = 1'b1;
                        res.value  = '0;
                        mode_next  = MODE_IDLE;
                    end
                end
                MODE_DEC: begin
                    if (is_dec) begin
                        accum_next = dec_acc;
                    end else begin
                        res.emit  = 1'b1;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_HEX1: begin
                    if (is_hex) begin
                        accum_next = {4'b0, hex_val};
                        mode_next  = MODE_HEX2;
                    end else begin
                        res.emit  = 1'b1;
                        mode_next = MODE_IDLE;
                    end
                end
                MODE_HEX2: begin
                    res.emit  = 1'b1;
                    mode_next = MODE_IDLE;
                    if (is_hex) begin
                        accum_next = {accum_reg[3:0], hex_val};
                        res.value  = {accum_reg[3:0], hex_val};
                    end
                end
                default: begin
                    // idle: a digit opens a literal, anything else is skipped
                    if (in_ch == CH_ZERO) begin
                        mode_next = MODE_ZERO;
                    end else if (is_dec) begin
                        accum_next = dec_val;
                        mode_next  = MODE_DEC;
                    end else begin
                        mode_next = MODE_IDLE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            accum_reg <= '0;
        end else if (advance) begin
            mode_reg  <= mode_next;
            accum_reg <= accum_next;
        end
    end

endmodule

// File: rtl/balp_out_reg.sv
// Result register presenting one parsed byte item to the output channel.
module balp_out_reg
    import balp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  step_res_t         res,
    output logic              out_free,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,
    output logic              m_tuser
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] data_reg;
    logic              end_reg;
    logic              load;

    assign out_free   = !valid_reg || m_tready;
    assign load       = advance && res.emit;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= res.value;
            end_reg  <= res.at_end;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;
    assign m_tuser  = end_reg;

endmodule

// File: rtl/byte_array_literal_parser.sv
// Byte array literal parser: top level joining input register, parse step and result register.
// Takes one text character per item (code 0 ends the text) and gives the bytes written in
// C array text: "0x" with one or two hex digits, runs of decimal digits taken modulo 256,
// and a lone '0'; all other characters are skipped. A literal cut short still gives its
// value, and the end character flushes any open literal with the end flag set, then
// clears the parse state. One item is accepted every cycle unless the output stalls; a character
// enters the input register, then the mode and accumulator update and any result is loaded
// into the result register together. Throughput drops only while a result waits for m_tready,
// as the single result register then holds the input register.
module byte_array_literal_parser
    import balp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [CH_W-1:0]   s_tdata,   // [7:0] ch
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [BYTE_W-1:0] m_tdata,   // [7:0] byte_value
    output logic              m_tuser    // [0] at_end
);

    logic            in_valid;
    logic [CH_W-1:0] in_ch;
    logic            out_free;
    logic            advance;
    step_res_t       res;

    assign advance = in_valid && out_free;

    balp_in_reg u_in_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .advance  (advance),
        .in_valid (in_valid),
        .in_ch    (in_ch)
    );

    balp_step u_step (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .in_ch   (in_ch),
        .res     (res)
    );

    balp_out_reg u_out_reg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .res      (res),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: rtl/balp_checker.sv
// Port-level checker for the byte array literal parser, bound to the top level.
module balp_checker
    import balp_pkg::*;
(
    input logic              aclk,
    input logic              aresetn,
    input logic              s_tvalid,
    input logic              s_tready,
    input logic [CH_W-1:0]   s_tdata,
    input logic              m_tvalid,
    input logic              m_tready,
    input logic [BYTE_W-1:0] m_tdata,
    input logic              m_tuser
);

    // hold a stalled result item unchanged
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result item changed while stalled");

    a_reset_clear: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // input back-pressure only ever comes from a stalled output
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output stall");

    // an empty result register never holds off the input
    a_ready_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input not ready with empty output");

    // a refused input item stays offered and unchanged
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata))
        else $error("input item changed while stalled");

endmodule

bind byte_array_literal_parser balp_checker u_balp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

// File: tb/byte_array_literal_parser_test.sv
// Self-checking stream testbench for the byte array literal parser, with its own parse predictor.
module byte_array_literal_parser_test;
    import balp_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 1800;
    localparam int unsigned CALM_TAIL    = 150;
    localparam int unsigned HOLD_AT      = 300;
    localparam int unsigned HOLD_CYCLES  = 64;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = 10;

    typedef struct packed {
        logic [BYTE_W-1:0] value;
        logic              at_end;
    } byte_item_t;

    logic              aclk;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [CH_W-1:0]   s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [BYTE_W-1:0] m_tdata;
    logic              m_tuser;

    logic [CH_W-1:0]   char_q[$];
    byte_item_t        byte_q[$];
    mode_t             cur_mode = MODE_IDLE;
    logic [BYTE_W-1:0] cur_acc  = '0;
    logic              s_took   = 1'b0;
    int unsigned       chars_taken = 0;
    int unsigned       fails = 0;

    byte_array_literal_parser dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $realtime, msg);
        fails++;
    endtask

    function automatic bit is_digit(input logic [CH_W-1:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    function automatic int hex_digit(input logic [CH_W-1:0] c);
        if (is_digit(c)) return int'(c - CH_ZERO);
        if (c >= CH_UC_A && c <= CH_UC_F) return int'(c - UC_OFFSET);
        if (c >= CH_LC_A && c <= CH_LC_F) return int'(c - LC_OFFSET);
        return -1;
    endfunction

    // A character that cannot extend a literal is looked at afresh, as in idle.
    function automatic void enter_from_idle(input logic [CH_W-1:0] c);
        if (c == CH_ZERO) begin
            cur_mode = MODE_ZERO;
        end else if (is_digit(c)) begin
            cur_acc  = c - CH_ZERO;
            cur_mode = MODE_DEC;
        end else begin
            cur_mode = MODE_IDLE;
        end
    endfunction

    // Advance the parse state by one character; returns 1 when a byte comes out.
    function automatic bit parse_char(input logic [CH_W-1:0] c, output byte_item_t res);
        bit fire;
        int h;
        fire = 1'b0;
        res  = '0;
        h    = hex_digit(c);
        if (c == CH_END) begin
            if (cur_mode == MODE_ZERO) begin
                fire = 1'b1;
                res  = '{value: '0, at_end: 1'b1};
            end else if (cur_mode inside {MODE_DEC, MODE_HEX1, MODE_HEX2}) begin
                fire = 1'b1;
                res  = '{value: cur_acc, at_end: 1'b1};
            end
            cur_mode = MODE_IDLE;
            cur_acc  = '0;
            return fire;
        end
        case (cur_mode)
            MODE_ZERO: begin
                if (c == CH_X) begin
                    cur_mode = MODE_HEX1;
                end else if (is_digit(c)) begin
                    cur_acc  = c - CH_ZERO;
                    cur_mode = MODE_DEC;
                end else begin
                    cur_acc = '0;
                    fire    = 1'b1;
                    res     = '{value: '0, at_end: 1'b0};
                    enter_from_idle(c);
                end
            end
            MODE_DEC: begin
                if (is_digit(c)) begin
                    cur_acc = cur_acc * 8'd10 + (c - CH_ZERO);
                end else begin
                    fire = 1'b1;
                    res  = '{value: cur_acc, at_end: 1'b0};
                    enter_from_idle(c);
                end
            end
            MODE_HEX1: begin
                if (h >= 0) begin
                    cur_acc  = h[BYTE_W-1:0];
                    cur_mode = MODE_HEX2;
                end else begin
                    fire = 1'b1;
                    res  = '{value: cur_acc, at_end: 1'b0};
                    enter_from_idle(c);
                end
            end
            MODE_HEX2: begin
                fire = 1'b1;
                if (h >= 0) begin
                    cur_acc  = {cur_acc[3:0], h[3:0]};
                    res      = '{value: cur_acc, at_end: 1'b0};
                    cur_mode = MODE_IDLE;
                end else begin
                    res = '{value: cur_acc, at_end: 1'b0};
                    enter_from_idle(c);
                end
            end
            default: enter_from_idle(c);
        endcase
        return fire;
    endfunction

    task automatic push_text(input string t);
        for (int i = 0; i < t.len(); i++) char_q.push_back(t[i]);
    endtask

    // Random C array text: mostly well-formed literals, with junk, cut-off prefixes and ends.
    task automatic build_random_text();
        int unsigned pick;
        int unsigned n;
        int unsigned v;
        string seps;
        seps = ", {}\n";
        while (char_q.size() < RANDOM_ITEMS + 26) begin
            pick = $urandom_range(0, 99);
            if (pick < 35) begin
                push_text("0x");
                n = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 2);
                for (int i = 0; i < n; i++) begin
                    v = $urandom_range(0, 15);
                    if (v < 10) char_q.push_back(CH_ZERO + v[CH_W-1:0]);
                    else if ($urandom_range(0, 1) != 0) char_q.push_back(UC_OFFSET + v[CH_W-1:0]);
                    else char_q.push_back(LC_OFFSET + v[CH_W-1:0]);
                end
            end else if (pick < 65) begin
                n = $urandom_range(1, 4);
                for (int i = 0; i < n; i++) char_q.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
            end else if (pick < 72) begin
                char_q.push_back(CH_ZERO);
            end else if (pick < 82) begin
                char_q.push_back(8'($urandom_range(1, 255)));
            end else if (pick < 86) begin
                char_q.push_back(CH_END);
            end
            if ($urandom_range(0, 4) != 0) char_q.push_back(seps[$urandom_range(0, 4)]);
        end
    endtask

    initial begin
        // Directed: mixed-case hex, third hex digit, flush of a decimal run at end of text,
        // bare prefix with stale and cleared accumulator, lone zero, wrap modulo 256.
        push_text("{0x1F,0xab7");
        char_q.push_back(CH_END);
        push_text("0xz0,");
        char_q.push_back(CH_END);
        push_text("999");
        char_q.push_back(8'hFF);
        push_text("0x");
        char_q.push_back(CH_END);
        char_q.push_back(CH_END);
        build_random_text();
        repeat (12) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;
        while (char_q.size() != 0 || s_tvalid || byte_q.size() != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
        if (fails == 0) begin
            $display("byte_array_literal_parser verification clean");
        end else begin
            $display("byte_array_literal_parser verification failed");
        end
        $finish;
    end

    // Sender: hold an item until taken, otherwise idle in bursts or offer the next one.
    always @(negedge aclk) begin : sender
        int unsigned gap_left;
        if (!aresetn) begin
            gap_left = 0;
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !s_took) begin
            s_tvalid <= 1'b1;
        end else if (gap_left > 0) begin
            gap_left--;
            s_tvalid <= 1'b0;
        end else if (char_q.size() == 0) begin
            s_tvalid <= 1'b0;
        end else if (char_q.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
            gap_left = $urandom_range(0, 3);
            s_tvalid <= 1'b0;
        end else begin
            s_tdata  <= char_q.pop_front();
            s_tvalid <= 1'b1;
        end
    end

    // Receiver: short stalls in bursts, and one long hold-off to back the block up.
    always @(negedge aclk) begin : receiver
        int unsigned stall_left;
        bit          held;
        if (!aresetn) begin
            stall_left = 0;
            held       = 1'b0;
            m_tready <= 1'b0;
        end else if (!held && chars_taken >= HOLD_AT) begin
            held       = 1'b1;
            stall_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            m_tready <= 1'b0;
        end else if (char_q.size() > CALM_TAIL && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(0, 3);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Check each result against the oldest expectation, then predict from any accepted item.
    always @(posedge aclk) begin : monitor
        byte_item_t want;
        byte_item_t next;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (byte_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected byte %02h at_end %0b",
                                              m_tdata, m_tuser));
                end else begin
                    want = byte_q.pop_front();
                    if (m_tdata !== want.value)
                        report_mismatch($sformatf("byte_value got %02h want %02h",
                                                  m_tdata, want.value));
                    if (m_tuser !== want.at_end)
                        report_mismatch($sformatf("at_end got %0b want %0b",
                                                  m_tuser, want.at_end));
                end
            end
            if (s_tvalid && s_tready) begin
                chars_taken++;
                if (parse_char(s_tdata, next)) byte_q.push_back(next);
            end
        end
        s_took <= aresetn && s_tvalid && s_tready;
    end

    always @(posedge aclk) begin : watchdog
        int unsigned quiet_cycles;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("byte_array_literal_parser verification failed");
                $finish;
            end
        end
    end

endmodule

// File: files.f
rtl/balp_pkg.sv
rtl/balp_in_reg.sv
rtl/balp_step.sv
rtl/balp_out_reg.sv
rtl/byte_array_literal_parser.sv
rtl/balp_checker.sv
tb/byte_array_literal_parser_test.sv
